// File: sv/b2n_pkg.sv
package b2n_pkg;

  // Message bytes are eight bits wide.
  localparam int unsigned BYTE_BITS = 8;

  localparam int unsigned ACC_W    = 16;  // bit accumulator
  localparam int unsigned HELD_W   = 4;   // pending bit count
  localparam int unsigned POS_W    = 4;   // position inside a padding block
  localparam int unsigned SYM_W    = 7;   // symbol index
  localparam int unsigned SBITS_W  = 3;   // symbol_bits register
  localparam int unsigned BSIZE_W  = 5;   // block_size register
  localparam int unsigned CFG_W    = 5;   // configuration data port
  localparam int unsigned CFG_IDX_W = 1;

  // Shift amount into the {acc, 7'b0} window: held + 7 - symbol_bits <= 14.
  localparam int unsigned SHAMT_W  = 5;

  localparam logic [BSIZE_W-1:0] BSIZE_MAX = 5'd16;

  localparam logic [SBITS_W-1:0] SBITS_RST = 3'd6;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = 5'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

  // What the sequencer puts out in one step.
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FLUSH,
    KIND_PAD
  } kind_e;

endpackage

// File: sv/base2n_symbol_encoder_top.sv
// Base-2^n symbol encoder (base64/base32/base16 style, alphabet mapping done
// downstream). Each accepted input word carries an optional message byte and
// an end-of-message flag; the block emits one output word per symbol, most
// significant group first, then on end of message one left-justified flush
// symbol for leftover bits and pad markers (is_pad, index 0) up to a multiple
// of block_size. last_of_run marks the final output word caused by an input
// word; an input that causes nothing (no byte and no end, or a bare end on an
// empty message) produces no output. Timing: an input word is taken, and then
// the shared shift unit produces one symbol per cycle while the output
// register is free, giving N outputs per word (N = 1..2 per byte for base64,
// up to 23 with padding); no new word is taken until the last is issued. The
// output register lets the next input word be taken while the last symbol
// still waits downstream. in_ready_o is low while symbols are being issued.
// Configuration writes (symbol_bits at index 0, block_size at index 1) take
// effect at once, clear the message state, and must only be made while idle.
module base2n_symbol_encoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [b2n_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [b2n_pkg::CFG_W-1:0]       cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [b2n_pkg::BYTE_BITS-1:0]   data_byte_i,
  input  logic                            byte_valid_i,
  input  logic                            end_of_message_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [b2n_pkg::SYM_W-1:0]       symbol_index_o,
  output logic                            is_pad_o,
  output logic                            last_of_run_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [b2n_pkg::SBITS_W-1:0] sbits_q, sbits_d;
  logic [b2n_pkg::BSIZE_W-1:0] bsize_q, bsize_d;
  logic [b2n_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [b2n_pkg::HELD_W-1:0]  held_q, held_d;
  logic [b2n_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                        end_q, end_d;

  logic                        out_valid_q, out_valid_d;
  logic [b2n_pkg::SYM_W-1:0]   sym_q, sym_d;
  logic                        pad_q, pad_d;
  logic                        last_q, last_d;

  // effective configuration
  logic [b2n_pkg::SBITS_W-1:0] sb_eff;
  logic [b2n_pkg::BSIZE_W-1:0] bs_eff;

  logic                        in_acc;
  logic                        out_free;
  logic [b2n_pkg::ACC_W-1:0]   acc_ld;
  logic [b2n_pkg::HELD_W-1:0]  held_ld;
  logic                        any_ld;

  b2n_pkg::kind_e              kind;
  logic [b2n_pkg::SYM_W-1:0]   unit_sym;
  logic [b2n_pkg::HELD_W-1:0]  held_n;
  logic [b2n_pkg::POS_W-1:0]   pos_n;
  logic                        more_n;

  // Another symbol is due for this item given the pending state.
  function automatic logic more_due(
    input logic [b2n_pkg::HELD_W-1:0]  held,
    input logic                        eom,
    input logic [b2n_pkg::POS_W-1:0]   pos,
    input logic [b2n_pkg::SBITS_W-1:0] sb,
    input logic [b2n_pkg::BSIZE_W-1:0] bs
  );
    logic r;
    r = (held >= b2n_pkg::HELD_W'(sb))
        || (eom && (held != '0))
        || (eom && (bs != '0) && (pos != '0));
    return r;
  endfunction

  function automatic logic [b2n_pkg::POS_W-1:0] pos_advance(
    input logic [b2n_pkg::POS_W-1:0]   pos,
    input logic [b2n_pkg::BSIZE_W-1:0] bs
  );
    logic [b2n_pkg::POS_W-1:0] p1;
    logic [b2n_pkg::POS_W-1:0] r;
    p1 = pos + b2n_pkg::POS_W'(1);
    if (bs == '0) begin
      r = '0;
    end else if (b2n_pkg::BSIZE_W'(p1) >= bs) begin
      r = '0;
    end else begin
      r = p1;
    end
    return r;
  endfunction

  assign sb_eff = (sbits_q == '0) ? b2n_pkg::SBITS_W'(1) : sbits_q;
  assign bs_eff = (bsize_q > b2n_pkg::BSIZE_MAX) ? b2n_pkg::BSIZE_MAX : bsize_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // New byte appended to the accumulator; upper bits past held are don't-care.
  assign acc_ld  = byte_valid_i ? {acc_q[b2n_pkg::ACC_W-b2n_pkg::BYTE_BITS-1:0], data_byte_i}
                                : acc_q;
  assign held_ld = byte_valid_i ? held_q + b2n_pkg::HELD_W'(b2n_pkg::BYTE_BITS) : held_q;
  assign any_ld  = more_due(held_ld, end_of_message_i, pos_q, sb_eff, bs_eff);

  // Step kind: full groups first, then the flush, then pads.
  always_comb begin
    if (held_q >= b2n_pkg::HELD_W'(sb_eff)) begin
      kind = b2n_pkg::KIND_DATA;
    end else if (held_q != '0) begin
      kind = b2n_pkg::KIND_FLUSH;
    end else begin
      kind = b2n_pkg::KIND_PAD;
    end
  end

  b2n_shift_unit u_shift (
    .acc_i   (acc_q),
    .held_i  (held_q),
    .sbits_i (sb_eff),
    .sym_o   (unit_sym)
  );

  assign held_n = (kind == b2n_pkg::KIND_DATA) ? held_q - b2n_pkg::HELD_W'(sb_eff) : '0;
  assign pos_n  = pos_advance(pos_q, bs_eff);
  assign more_n = more_due(held_n, end_q, pos_n, sb_eff, bs_eff);

  always_comb begin
    state_d     = state_q;
    sbits_d     = sbits_q;
    bsize_d     = bsize_q;
    acc_d       = acc_q;
    held_d      = held_q;
    pos_d       = pos_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sym_d       = sym_q;
    pad_d       = pad_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d  = acc_ld;
          held_d = held_ld;
          end_d  = end_of_message_i;
          if (any_ld) begin
            state_d = ST_EMIT;
          end else if (end_of_message_i) begin
            acc_d  = '0;
            held_d = '0;
            pos_d  = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pad_d       = (kind == b2n_pkg::KIND_PAD);
          sym_d       = (kind == b2n_pkg::KIND_PAD) ? '0 : unit_sym;
          last_d      = !more_n;
          held_d      = held_n;
          pos_d       = pos_n;
          if (!more_n) begin
            state_d = ST_IDLE;
            if (end_q) begin
              acc_d  = '0;
              held_d = '0;
              pos_d  = '0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // register write restarts the message
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        b2n_pkg::REG_SYMBOL_BITS: sbits_d = cfg_data_i[b2n_pkg::SBITS_W-1:0];
        b2n_pkg::REG_BLOCK_SIZE:  bsize_d = cfg_data_i[b2n_pkg::BSIZE_W-1:0];
        default: ;
      endcase
      acc_d  = '0;
      held_d = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sbits_q     <= b2n_pkg::SBITS_RST;
      bsize_q     <= b2n_pkg::BSIZE_RST;
      acc_q       <= '0;
      held_q      <= '0;
      pos_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sbits_q     <= sbits_d;
      bsize_q     <= bsize_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    pad_q  <= pad_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_index_o = sym_q;
  assign is_pad_o       = pad_q;
  assign last_of_run_o  = last_q;

`ifndef ASSERT_OFF
  a_pad_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pad_q |-> sym_q == '0)
    else $error("pad word with nonzero index");

  a_pad_needs_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pad_q |-> bs_eff != '0)
    else $error("pad word with padding disabled");

  a_sym_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sym_q >> sb_eff) == '0)
    else $error("symbol index wider than symbol_bits");

  a_idle_held_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> held_q < b2n_pkg::HELD_W'(sb_eff))
    else $error("full group left pending between words");

  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bs_eff == '0 && pos_q == '0) || (bs_eff != '0 && b2n_pkg::BSIZE_W'(pos_q) < bs_eff))
    else $error("block position out of range");
`endif

endmodule

// File: sv/b2n_shift_unit.sv
// Shared symbol extractor. The accumulator is viewed as {acc, 7'b0}; a right
// shift by held + 7 - sb yields both a full group (held >= sb) and the
// left-justified remainder on a flush (held < sb).
module b2n_shift_unit (
  input  logic [b2n_pkg::ACC_W-1:0]   acc_i,
  input  logic [b2n_pkg::HELD_W-1:0]  held_i,
  input  logic [b2n_pkg::SBITS_W-1:0] sbits_i,
  output logic [b2n_pkg::SYM_W-1:0]   sym_o
);

  localparam int unsigned WIN_W = b2n_pkg::ACC_W + b2n_pkg::SYM_W;

  logic [WIN_W-1:0]               window;
  logic [WIN_W-1:0]               shifted;
  logic [b2n_pkg::SHAMT_W-1:0]    shamt;
  logic [b2n_pkg::SYM_W-1:0]      mask;

  assign window  = {acc_i, {b2n_pkg::SYM_W{1'b0}}};
  assign shamt   = b2n_pkg::SHAMT_W'(held_i) + b2n_pkg::SHAMT_W'(b2n_pkg::SYM_W)
                   - b2n_pkg::SHAMT_W'(sbits_i);
  assign shifted = window >> shamt;
  assign mask    = b2n_pkg::SYM_W'((8'd1 << sbits_i) - 8'd1);
  assign sym_o   = shifted[b2n_pkg::SYM_W-1:0] & mask;

endmodule
